FILE: rtl/core/spb_pkg.sv
// Shared types, widths and constants for the spectrum bar / peak hold block.
// No dependencies; every other file in rtl/core imports this package.
package spb_pkg;

    // Peak store geometry (power of two, column index wraps on the low bits)
    localparam int COLUMNS  = 1024;
    localparam int ADDR_W   = $clog2(COLUMNS);

    // Field widths
    localparam int COL_W    = 10;
    localparam int MAG_W    = 16;
    localparam int ROW_W    = 16;
    localparam int HEIGHT_W = 10;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd768;

    // Scaled product width (height * (65536 - 30*m) fits in 32 bits signed)
    localparam int PROD_W   = 32;

    // Divide by ten: q * 52429 >> 19 is exact for any 16-bit q
    localparam int              RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_10 = 17'd52429;
    localparam int              RECIP_SHIFT = 19;
    localparam int              QUOT_W      = 12;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [MAG_W-1:0] magnitude;
        logic             low_band;
    } spb_in_t;

    typedef struct packed {
        logic signed [ROW_W-1:0] bar_top;
        logic signed [ROW_W-1:0] peak_row;
    } spb_out_t;

    // Peak store write port
    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic signed [ROW_W-1:0] data;
    } spb_wr_t;

    // Column to store address
    function automatic logic [ADDR_W-1:0] col_addr(input logic [COL_W-1:0] column);
        return ADDR_W'(column);
    endfunction

endpackage

FILE: rtl/core/spectrum_bar_peak_hold.sv
// Spectrum bar top and falling peak marker, one display column per word.
// Pipeline: input, scale and fold stages, then a result register; a stage
// advances when the next is free or moving. Throughput: one word per cycle
// while result_ready and the reset sweep allow it, limited by the single write
// port of the peak store. Reset: height returns to 768 and a sweep zeroes the
// peak store; item_ready stays low during the sweep.
module spectrum_bar_peak_hold (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [spb_pkg::HEIGHT_W-1:0]  cfg_wr_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  spb_pkg::spb_in_t              item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output spb_pkg::spb_out_t             result
);
    import spb_pkg::*;

    logic [HEIGHT_W-1:0] height_reg;

    // stage 1: input register
    logic                 s1_valid_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [MAG_W-1:0]     s1_mag_reg;
    logic                 s1_low_reg;

    // stage 2: scaled product
    logic                      s2_valid_reg;
    logic [ADDR_W-1:0]         s2_addr_reg;
    logic                      s2_low_reg;
    logic signed [PROD_W-1:0]  s2_prod_reg;

    // stage 3: raw bar and its tenth; peak read arrives here
    logic                     s3_valid_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;
    logic                     s3_low_reg;
    logic                     s3_neg_reg;
    logic signed [ROW_W-1:0]  s3_bar0_reg;
    logic [QUOT_W-1:0]        s3_quot_reg;

    // result register
    logic      out_valid_reg;
    spb_out_t  out_reg;

    logic s1_move, s2_move, s3_move;
    logic ram_busy;

    logic signed [PROD_W-1:0]      s1_prod;
    logic                          s2_neg;
    logic [PROD_W-1:0]             s2_abs;
    logic [ROW_W-1:0]              s2_q;
    logic signed [ROW_W-1:0]       s2_bar0;
    logic [ROW_W+RECIP_W-1:0]      s2_qmul;

    logic signed [ROW_W-1:0] s3_mid;
    logic signed [ROW_W-1:0] s3_quot;
    logic signed [ROW_W-1:0] s3_bar;
    logic signed [ROW_W-1:0] peak_old;
    logic signed [ROW_W-1:0] peak_new;
    spb_wr_t                 peak_wr;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            height_reg <= cfg_wr_data;
        end
    end

    // Stage advance: each stage moves when the next one is free or moving
    assign s3_move    = s3_valid_reg && (!out_valid_reg || result_ready);
    assign s2_move    = s2_valid_reg && (!s3_valid_reg || s3_move);
    assign s1_move    = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign item_ready = !ram_busy && (!s1_valid_reg || s1_move);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_move)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (s3_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 capture
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_addr_reg <= col_addr(item.column);
            s1_mag_reg  <= item.magnitude;
            s1_low_reg  <= item.low_band;
        end
    end

    spb_bar_scale u_scale (
        .height    (height_reg),
        .magnitude (s1_mag_reg),
        .product   (s1_prod)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_low_reg  <= s1_low_reg;
            s2_prod_reg <= s1_prod;
        end
    end

    // Stage 2: divide by 65536 toward zero, then |bar| / 10
    always_comb
    begin
        s2_neg  = s2_prod_reg[PROD_W-1];
        s2_abs  = s2_neg ? PROD_W'(-s2_prod_reg) : PROD_W'(s2_prod_reg);
        s2_q    = s2_abs[PROD_W-1 -: ROW_W];
        s2_bar0 = s2_neg ? -$signed(s2_q) : $signed(s2_q);
        s2_qmul = s2_q * RECIP_10;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_addr_reg <= s2_addr_reg;
            s3_low_reg  <= s2_low_reg;
            s3_neg_reg  <= s2_neg;
            s3_bar0_reg <= s2_bar0;
            s3_quot_reg <= s2_qmul[RECIP_SHIFT +: QUOT_W];
        end
    end

    // Stage 3: low-band compression above mid-screen
    always_comb
    begin
        s3_mid  = $signed({{(ROW_W-HEIGHT_W+1){1'b0}}, height_reg[HEIGHT_W-1:1]});
        s3_quot = s3_neg_reg ? -$signed({{(ROW_W-QUOT_W){1'b0}}, s3_quot_reg})
                             : $signed({{(ROW_W-QUOT_W){1'b0}}, s3_quot_reg});
        if (s3_low_reg && (s3_bar0_reg < s3_mid))
        begin
            s3_bar = s3_mid + s3_quot;
        end
        else
        begin
            s3_bar = s3_bar0_reg;
        end
    end

    spb_peak_step u_step (
        .bar      (s3_bar),
        .peak_old (peak_old),
        .peak_new (peak_new)
    );

    // Peak store: read as a word enters stage 3, write as it leaves
    always_comb
    begin
        peak_wr.en   = s3_move;
        peak_wr.addr = s3_addr_reg;
        peak_wr.data = peak_new;
    end

    spb_peak_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (peak_wr),
        .rd_en   (s2_move),
        .rd_addr (s2_addr_reg),
        .rd_data (peak_old),
        .busy    (ram_busy)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            out_reg.bar_top  <= s3_bar;
            out_reg.peak_row <= peak_new;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/core/spb_bar_scale.sv
// Bar scaling: signed product height * (65536 - 30*magnitude).
// Depends on spb_pkg.
module spb_bar_scale (
    input  logic [spb_pkg::HEIGHT_W-1:0]      height,
    input  logic [spb_pkg::MAG_W-1:0]         magnitude,
    output logic signed [spb_pkg::PROD_W-1:0] product
);
    import spb_pkg::*;

    logic [20:0]        mag_x30;
    logic signed [22:0] factor;
    logic signed [33:0] full;

    // 30*m as shift and subtract, then one multiply by the height
    always_comb
    begin
        mag_x30 = {magnitude, 5'b0} - {4'b0, magnitude, 1'b0};
        factor  = 23'sd65536 - $signed({2'b00, mag_x30});
        full    = $signed({1'b0, height}) * factor;
        product = $signed(full[PROD_W-1:0]);
    end

endmodule

FILE: rtl/core/spb_peak_step.sv
// Peak marker update: snap to bar - 2 or fall by a gap-dependent step.
// Depends on spb_pkg.
module spb_peak_step (
    input  logic signed [spb_pkg::ROW_W-1:0] bar,
    input  logic signed [spb_pkg::ROW_W-1:0] peak_old,
    output logic signed [spb_pkg::ROW_W-1:0] peak_new
);
    import spb_pkg::*;

    logic signed [ROW_W:0] bar_x;
    logic signed [ROW_W:0] peak_x;
    logic signed [ROW_W:0] gap;
    logic signed [ROW_W:0] peak_next;

    always_comb
    begin
        bar_x  = {bar[ROW_W-1], bar};
        peak_x = {peak_old[ROW_W-1], peak_old};
        gap    = bar_x - peak_x;
        // bar reached the marker, or marker at or above the top row
        if ((bar_x - 17'sd1) <= peak_x || peak_x <= 17'sd0)
        begin
            peak_next = bar_x - 17'sd2;
        end
        else if (gap > 17'sd300)
        begin
            peak_next = peak_x + 17'sd5;
        end
        else if (gap > 17'sd200)
        begin
            peak_next = peak_x + 17'sd4;
        end
        else if (gap > 17'sd100)
        begin
            peak_next = peak_x + 17'sd3;
        end
        else if (gap > 17'sd10)
        begin
            peak_next = peak_x + 17'sd2;
        end
        else
        begin
            peak_next = peak_x + 17'sd1;
        end
        peak_new = peak_next[ROW_W-1:0];
    end

endmodule

FILE: rtl/core/spb_peak_ram.sv
// Per-column peak store: one write and one registered read port, write bypass,
// and a zeroing sweep after reset. Depends on spb_pkg.
module spb_peak_ram (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spb_pkg::spb_wr_t                wr,
    input  logic                            rd_en,
    input  logic [spb_pkg::ADDR_W-1:0]      rd_addr,
    output logic signed [spb_pkg::ROW_W-1:0] rd_data,
    output logic                            busy
);
    import spb_pkg::*;

    logic signed [ROW_W-1:0] mem [COLUMNS];
    logic signed [ROW_W-1:0] rd_data_reg;
    logic signed [ROW_W-1:0] byp_data_reg;
    logic                    byp_hit_reg;
    logic                    clr_busy_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    spb_wr_t                 port;

    // Sweep has the write port until every entry is zeroed
    always_comb
    begin
        if (clr_busy_reg)
        begin
            port.en   = 1'b1;
            port.addr = clr_addr_reg;
            port.data = '0;
        end
        else
        begin
            port = wr;
        end
    end

    // Clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(COLUMNS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Memory array
    always_ff @(posedge clk)
    begin
        if (port.en)
        begin
            mem[port.addr] <= port.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Same-edge write to the read address wins
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_hit_reg  <= port.en && (port.addr == rd_addr);
            byp_data_reg <= port.data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule
